@@ hdl/skd_pkg.sv @@
`timescale 1ns / 1ps
package skd_pkg;

   localparam int DEF_LOOKBACK   = 8;
   localparam int DEF_PRICE_BITS = 24;

   localparam int VALUE_BITS  = 23;
   localparam int SUM_BITS    = 25;
   localparam int RECIP_BITS  = 26;
   localparam int RECIP_SHIFT = 27;

   localparam logic [VALUE_BITS-1:0] FULL_SCALE  = 23'd6553600;
   localparam logic [RECIP_BITS-1:0] RECIP_THREE = 26'd44739243;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_K_MUL,
      ST_K_SET,
      ST_D_MUL,
      ST_D_SET,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      REL_EQUAL = 2'd0,
      REL_BELOW = 2'd1,
      REL_ABOVE = 2'd2
   } rel_type;

   typedef enum logic [1:0] {
      CROSS_NONE   = 2'd0,
      CROSS_GOLDEN = 2'd1,
      CROSS_DEATH  = 2'd2
   } cross_type;

   typedef enum logic [1:0] {
      MSEL_RANGE,
      MSEL_K,
      MSEL_D
   } mul_sel_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ hdl/skd_ifs.sv @@
`timescale 1ns / 1ps
interface skd_req_if #(
   parameter int PRICE_BITS = skd_pkg::DEF_PRICE_BITS
);
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] close_price;
   logic [PRICE_BITS-1:0] high_price;
   logic [PRICE_BITS-1:0] low_price;
   logic                  series_start;

   modport source (output valid, close_price, high_price, low_price, series_start,
                   input ready);
   modport sink (input valid, close_price, high_price, low_price, series_start,
                 output ready);
endinterface

interface skd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [skd_pkg::VALUE_BITS-1:0] k_line;
   logic [skd_pkg::VALUE_BITS-1:0] d_line;
   logic                           k_ready;
   logic                           d_ready;
   logic [1:0]                     cross_kind;
   logic                           flat_range;

   modport source (output valid, k_line, d_line, k_ready, d_ready, cross_kind, flat_range,
                   input ready);
   modport sink (input valid, k_line, d_line, k_ready, d_ready, cross_kind, flat_range,
                 output ready);
endinterface

@@ hdl/skd_div.sv @@
`timescale 1ns / 1ps
module skd_div #(
   parameter int PRICE_BITS = skd_pkg::DEF_PRICE_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [PRICE_BITS+skd_pkg::VALUE_BITS-1:0]   num,
   input  logic [PRICE_BITS-1:0]                       den,
   output skd_pkg::div_stat_type                       stat,
   output logic [skd_pkg::VALUE_BITS-1:0]              quot
);

   localparam int QB    = skd_pkg::VALUE_BITS;
   localparam int CNT_W = $clog2(QB + 1);

   logic [PRICE_BITS-1:0] rem_ff, rem_in;
   logic [PRICE_BITS-1:0] den_ff;
   logic [QB-1:0]         low_ff;
   logic [QB-1:0]         quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [PRICE_BITS:0]   trial;
   logic                  fits;

   // one quotient bit per cycle, remainder stays below the divisor
   always_comb begin
      trial   = {rem_ff, low_ff[QB-1]};
      fits    = trial >= {1'b0, den_ff};
      rem_in  = fits ? PRICE_BITS'(trial - {1'b0, den_ff}) : trial[PRICE_BITS-1:0];
      quot_in = {quot_ff[QB-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= num[PRICE_BITS+QB-1:QB];
            low_ff  <= num[QB-1:0];
            den_ff  <= den;
            cnt_ff  <= CNT_W'(QB);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            low_ff  <= {low_ff[QB-2:0], 1'b0};
            quot_ff <= quot_in;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && cnt_ff == CNT_W'(QB))
      else $error("divider did not load");

   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");

endmodule

@@ hdl/stochastic_kd_cross_detector_top.sv @@
`timescale 1ns / 1ps
// sequence: an accepted item runs the window scan and the range multiply, then the range division when
//   the raw value is not clipped or flat and the window has filled, then the K and D smoothing steps
// flow: no new item is taken until the last result has been loaded for output; the 23-step divider and the
//   one-entry-per-cycle window scan, with one shared multiplier for scaling and the thirds, pace each item
// reset: synchronous, clears window, bar count, histories and result valid; first item is bar 0
module stochastic_kd_cross_detector_top #(
   parameter int LOOKBACK   = skd_pkg::DEF_LOOKBACK,
   parameter int PRICE_BITS = skd_pkg::DEF_PRICE_BITS
) (
   input logic        clock,
   input logic        reset,
   skd_req_if.sink    req_ch,
   skd_rsp_if.source  rsp_ch
);

   localparam int VB          = skd_pkg::VALUE_BITS;
   localparam int DEPTH       = LOOKBACK + 1;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int K_START     = LOOKBACK + 2;
   localparam int D_START     = LOOKBACK + 4;
   localparam int CROSS_START = LOOKBACK + 5;
   localparam int CNT_W       = $clog2(CROSS_START + 1);
   localparam int MUL_A       = (PRICE_BITS > skd_pkg::SUM_BITS) ? PRICE_BITS
                                                                 : skd_pkg::SUM_BITS;
   localparam int PROD_W      = MUL_A + skd_pkg::RECIP_BITS;
   localparam int NUM_W       = PRICE_BITS + VB;

   skd_pkg::state_type    state_ff, state_in;
   skd_pkg::mul_sel_type  mul_sel;
   skd_pkg::rel_type      rel_ff, rel_now;
   skd_pkg::cross_type    cross_ff, cross_now;
   skd_pkg::div_stat_type div_stat;

   logic [PRICE_BITS-1:0] high_win_ff [DEPTH];
   logic [PRICE_BITS-1:0] high_win_in [DEPTH];
   logic [PRICE_BITS-1:0] low_win_ff  [DEPTH];
   logic [PRICE_BITS-1:0] low_win_in  [DEPTH];

   logic [CNT_W-1:0]      bar_count_ff, idx_ff, new_idx;
   logic [IDX_W-1:0]      scan_ff;
   logic [PRICE_BITS-1:0] close_ff, hh_ff, ll_ff, high_sel, low_sel;
   logic [VB-1:0]         raw_ff, k_ff, d_ff;
   logic [VB-1:0]         raw_hist_ff [2];
   logic [VB-1:0]         k_hist_ff   [2];
   logic [VB-1:0]         d_prev_ff;
   logic                  flat_ff;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   logic                  rsp_valid_ff, k_rdy_ff, d_rdy_ff, flat_out_ff;
   logic [VB-1:0]         k_out_ff, d_out_ff;

   logic                  accept, req_ready, div_start, load_out, out_free;
   logic                  scan_last, active, flat_now, low_clip, high_clip, need_div;
   logic                  first, neg;
   logic [VB-1:0]         tgt, prv, seed_b, seed_c, mag, third, smooth_val;
   logic [skd_pkg::SUM_BITS-1:0]   seed_sum;
   logic [MUL_A-1:0]               mul_a;
   logic [skd_pkg::RECIP_BITS-1:0] mul_b;
   logic [VB-1:0]                  div_quot;

   assign accept   = req_ch.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign new_idx  = req_ch.series_start ? '0 : bar_count_ff;

   // window shift on accept, series start empties older entries
   always_comb begin
      high_win_in = high_win_ff;
      low_win_in  = low_win_ff;
      if (accept) begin
         high_win_in[0] = req_ch.high_price;
         low_win_in[0]  = req_ch.low_price;
         for (int j = 1; j < DEPTH; j++) begin
            high_win_in[j] = req_ch.series_start ? '0 : high_win_ff[j-1];
            low_win_in[j]  = req_ch.series_start ? '0 : low_win_ff[j-1];
         end
      end
   end

   assign high_sel  = high_win_ff[scan_ff];
   assign low_sel   = low_win_ff[scan_ff];
   assign scan_last = scan_ff == IDX_W'(DEPTH - 1);

   assign active    = idx_ff >= CNT_W'(LOOKBACK);
   assign flat_now  = active && (hh_ff <= ll_ff);
   assign low_clip  = close_ff <= ll_ff;
   assign high_clip = close_ff >= hh_ff;
   assign need_div  = active && !flat_now && !low_clip && !high_clip;

   // operands for the shared multiplier
   always_comb begin
      if (mul_sel == skd_pkg::MSEL_D) begin
         tgt    = k_ff;
         prv    = d_prev_ff;
         seed_b = k_hist_ff[0];
         seed_c = k_hist_ff[1];
         first  = idx_ff == CNT_W'(D_START);
      end else begin
         tgt    = raw_ff;
         prv    = k_hist_ff[0];
         seed_b = raw_hist_ff[0];
         seed_c = raw_hist_ff[1];
         first  = idx_ff == CNT_W'(K_START);
      end
      neg      = tgt < prv;
      mag      = neg ? prv - tgt : tgt - prv;
      seed_sum = skd_pkg::SUM_BITS'(tgt) + skd_pkg::SUM_BITS'(seed_b)
               + skd_pkg::SUM_BITS'(seed_c);
      if (mul_sel == skd_pkg::MSEL_RANGE) begin
         mul_a = MUL_A'(close_ff - ll_ff);
         mul_b = skd_pkg::RECIP_BITS'(skd_pkg::FULL_SCALE);
      end else begin
         mul_a = first ? MUL_A'(seed_sum) : MUL_A'(mag);
         mul_b = skd_pkg::RECIP_THREE;
      end
      third      = prod_ff[skd_pkg::RECIP_SHIFT +: VB];
      smooth_val = first ? third : (neg ? prv - third : prv + third);
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      if (k_ff < d_ff) begin
         rel_now = skd_pkg::REL_BELOW;
      end else if (k_ff > d_ff) begin
         rel_now = skd_pkg::REL_ABOVE;
      end else begin
         rel_now = skd_pkg::REL_EQUAL;
      end
      cross_now = skd_pkg::CROSS_NONE;
      if (idx_ff >= CNT_W'(CROSS_START)) begin
         priority if (rel_ff == skd_pkg::REL_BELOW && rel_now != skd_pkg::REL_BELOW) begin
            cross_now = skd_pkg::CROSS_GOLDEN;
         end else if (rel_ff == skd_pkg::REL_ABOVE && rel_now != skd_pkg::REL_ABOVE) begin
            cross_now = skd_pkg::CROSS_DEATH;
         end else begin
            cross_now = skd_pkg::CROSS_NONE;
         end
      end
   end

   skd_div #(
      .PRICE_BITS (PRICE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff[NUM_W-1:0]),
      .den   (hh_ff - ll_ff),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skd_pkg::ST_IDLE:      if (accept) state_in = skd_pkg::ST_SCAN;
         skd_pkg::ST_SCAN:      if (scan_last) state_in = skd_pkg::ST_MUL;
         skd_pkg::ST_MUL:       state_in = need_div ? skd_pkg::ST_DIV_START
                                                    : skd_pkg::ST_K_MUL;
         skd_pkg::ST_DIV_START: state_in = skd_pkg::ST_DIV_WAIT;
         skd_pkg::ST_DIV_WAIT:  if (div_stat.done) state_in = skd_pkg::ST_K_MUL;
         skd_pkg::ST_K_MUL:     state_in = skd_pkg::ST_K_SET;
         skd_pkg::ST_K_SET:     state_in = skd_pkg::ST_D_MUL;
         skd_pkg::ST_D_MUL:     state_in = skd_pkg::ST_D_SET;
         skd_pkg::ST_D_SET:     state_in = skd_pkg::ST_DONE;
         skd_pkg::ST_DONE:      if (out_free) state_in = skd_pkg::ST_IDLE;
         default:               state_in = skd_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = state_ff == skd_pkg::ST_IDLE;
      div_start = state_ff == skd_pkg::ST_DIV_START;
      load_out  = (state_ff == skd_pkg::ST_DONE) && out_free;
      unique case (state_ff)
         skd_pkg::ST_K_MUL, skd_pkg::ST_K_SET: mul_sel = skd_pkg::MSEL_K;
         skd_pkg::ST_D_MUL, skd_pkg::ST_D_SET: mul_sel = skd_pkg::MSEL_D;
         default:                              mul_sel = skd_pkg::MSEL_RANGE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DEPTH; j++) begin
            high_win_ff[j] <= '0;
            low_win_ff[j]  <= '0;
         end
      end else begin
         high_win_ff <= high_win_in;
         low_win_ff  <= low_win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= skd_pkg::ST_IDLE;
         bar_count_ff   <= '0;
         raw_hist_ff[0] <= '0;
         raw_hist_ff[1] <= '0;
         k_hist_ff[0]   <= '0;
         k_hist_ff[1]   <= '0;
         d_prev_ff      <= '0;
         rel_ff         <= skd_pkg::REL_EQUAL;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (accept) begin
            bar_count_ff <= (new_idx < CNT_W'(CROSS_START)) ? new_idx + 1'b1
                                                            : CNT_W'(CROSS_START);
            idx_ff       <= new_idx;
            close_ff     <= req_ch.close_price;
            hh_ff        <= req_ch.high_price;
            ll_ff        <= req_ch.low_price;
            scan_ff      <= IDX_W'(1);
            if (req_ch.series_start) begin
               raw_hist_ff[0] <= '0;
               raw_hist_ff[1] <= '0;
               k_hist_ff[0]   <= '0;
               k_hist_ff[1]   <= '0;
               d_prev_ff      <= '0;
               rel_ff         <= skd_pkg::REL_EQUAL;
            end
         end

         if (state_ff == skd_pkg::ST_SCAN) begin
            if (high_sel > hh_ff) hh_ff <= high_sel;
            if (low_sel < ll_ff) ll_ff <= low_sel;
            scan_ff <= scan_ff + 1'b1;
         end

         if (state_ff == skd_pkg::ST_MUL) begin
            prod_ff <= prod_in;
            flat_ff <= flat_now;
            raw_ff  <= (active && !flat_now && !low_clip && high_clip) ? skd_pkg::FULL_SCALE
                                                                       : '0;
         end

         if (state_ff == skd_pkg::ST_DIV_WAIT && div_stat.done) begin
            raw_ff <= div_quot;
         end

         if (state_ff == skd_pkg::ST_K_MUL || state_ff == skd_pkg::ST_D_MUL) begin
            prod_ff <= prod_in;
         end

         if (state_ff == skd_pkg::ST_K_SET) begin
            k_ff <= (idx_ff < CNT_W'(K_START)) ? '0 : smooth_val;
         end

         if (state_ff == skd_pkg::ST_D_SET) begin
            d_ff <= (idx_ff < CNT_W'(D_START)) ? '0 : smooth_val;
         end

         if (load_out) begin
            raw_hist_ff[1] <= raw_hist_ff[0];
            raw_hist_ff[0] <= raw_ff;
            k_hist_ff[1]   <= k_hist_ff[0];
            k_hist_ff[0]   <= k_ff;
            d_prev_ff      <= d_ff;
            if (idx_ff >= CNT_W'(D_START)) rel_ff <= rel_now;
            k_out_ff     <= k_ff;
            d_out_ff     <= d_ff;
            k_rdy_ff     <= idx_ff >= CNT_W'(K_START);
            d_rdy_ff     <= idx_ff >= CNT_W'(D_START);
            cross_ff     <= cross_now;
            flat_out_ff  <= flat_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.k_line     = k_out_ff;
   assign rsp_ch.d_line     = d_out_ff;
   assign rsp_ch.k_ready    = k_rdy_ff;
   assign rsp_ch.d_ready    = d_rdy_ff;
   assign rsp_ch.cross_kind = cross_ff;
   assign rsp_ch.flat_range = flat_out_ff;

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == skd_pkg::ST_SCAN)
      else $error("accepted item did not start the scan");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == skd_pkg::ST_DIV_WAIT |-> div_stat.busy || div_stat.done)
      else $error("waiting on an idle divider");

   a_raw_scale: assert property (@(posedge clock) disable iff (reset)
      state_ff == skd_pkg::ST_K_MUL |-> raw_ff <= skd_pkg::FULL_SCALE)
      else $error("raw value above full scale");

   a_kd_scale: assert property (@(posedge clock) disable iff (reset)
      state_ff == skd_pkg::ST_DONE |-> k_ff <= skd_pkg::FULL_SCALE
                                       && d_ff <= skd_pkg::FULL_SCALE)
      else $error("k or d above full scale");

   a_cross_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && cross_ff != skd_pkg::CROSS_NONE |-> k_rdy_ff && d_rdy_ff)
      else $error("cross reported before d is defined");

endmodule
